// ----- rtl/core/mcd_pkg.sv -----
// Shared types, constants and the control-word decode helper for the
// microcoded CPU datapath. No dependencies.
`default_nettype none

package mcd_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  localparam logic [15:0] PORT_ADDR  = 16'h2000;
  localparam logic [15:0] STACK_PAGE = 16'hff00;
  localparam logic [7:0]  CONST_BYTE = 8'hf1;

  localparam logic [23:0] CW_AI    = 24'h000001;
  localparam logic [23:0] CW_BI    = 24'h000002;
  localparam logic [23:0] CW_SPACT = 24'h000004;
  localparam logic [23:0] CW_HI    = 24'h000008;
  localparam logic [23:0] CW_K0    = 24'h000010;
  localparam logic [23:0] CW_K1    = 24'h000020;
  localparam logic [23:0] CW_K2    = 24'h000040;
  localparam logic [23:0] CW_K3    = 24'h000080;
  localparam logic [23:0] CW_K4    = 24'h000100;
  localparam logic [23:0] CW_RS    = 24'h000200;
  localparam logic [23:0] CW_PI    = 24'h000400;
  localparam logic [23:0] CW_PE    = 24'h000800;
  localparam logic [23:0] CW_II    = 24'h001000;
  localparam logic [23:0] CW_RI    = 24'h002000;
  localparam logic [23:0] CW_MI    = 24'h004000;
  localparam logic [23:0] CW_ME    = 24'h008000;
  localparam logic [23:0] CW_SPNOT = 24'h010000;
  localparam logic [23:0] CW_CI    = 24'h020000;
  localparam logic [23:0] CW_SPI   = 24'h040000;
  localparam logic [23:0] CW_FPI   = 24'h080000;
  localparam logic [23:0] CW_XO    = 24'h100000;
  localparam logic [23:0] CW_XI    = 24'h200000;
  localparam logic [23:0] CW_NOFLG = 24'h400000;
  localparam logic [23:0] CW_NONE  = 24'h000000;

  typedef enum logic {
    OP_EXEC = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_x;
    logic [15:0] pc;
    logic [15:0] mar;
    logic [15:0] sp;
    logic [15:0] fp;
    logic [7:0]  ir;
    logic [15:0] vtb;
    logic        carry;
    logic        zero;
    logic        int_en;
    logic        flg_sup;
  } arch_t;

  typedef struct packed {
    logic [7:0] bus;
    logic       eoi;
    logic       chr;
    logic       key;
    logic       ack;
  } step_res_t;

  typedef struct packed {
    logic                     we;
    logic [MEM_ADDR_BITS-1:0] addr;
    logic [7:0]               data;
  } mem_wr_t;

  // Signal present: all need bits set, no forbid bit set.
  function automatic logic sig(logic [23:0] cw, logic [23:0] need, logic [23:0] forbid);
    return ((cw & forbid) == 24'h0) && ((cw & need) == need);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mcd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old data. No dependencies.
`default_nettype none

module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mcd_exec.sv -----
// One datapath step: decode the control word, drive the bus, run the ALU and
// compute the next register state and memory write. Depends on mcd_pkg.
`default_nettype none

module mcd_exec (
  input  wire logic                 op,
  input  wire logic [23:0]          cw,
  input  wire logic [15:0]          load_address,
  input  wire logic [7:0]           load_data,
  input  wire logic [7:0]           irq_vector,
  input  wire logic [7:0]           key_byte,
  input  wire logic [7:0]           mem_rdata,
  input  wire mcd_pkg::arch_t       cur,
  output mcd_pkg::arch_t            nxt,
  output mcd_pkg::step_res_t        res,
  output mcd_pkg::mem_wr_t          wr
);

  always_comb begin
    logic [7:0]  bus;
    logic [9:0]  alu;
    logic        alu_hit;
    logic [15:0] s;
    mcd_pkg::arch_t st;

    st      = cur;
    bus     = 8'h00;
    alu     = 10'h000;
    alu_hit = 1'b0;
    s       = 16'h0000;
    res     = '0;
    wr      = '0;

    if (op == mcd_pkg::OP_LOAD) begin
      wr.we   = 1'b1;
      wr.addr = load_address[mcd_pkg::MEM_ADDR_BITS-1:0];
      wr.data = load_data;
    end else begin
      // phase one: sources
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K2,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        bus = mcd_pkg::sig(cw, mcd_pkg::CW_HI, mcd_pkg::CW_NONE) ? cur.sp[15:8] : cur.sp[7:0];
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K4)) begin
        bus = mcd_pkg::sig(cw, mcd_pkg::CW_HI, mcd_pkg::CW_NONE) ? cur.fp[15:8] : cur.fp[7:0];
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K3,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4))
        bus = cur.reg_a;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2,
                       mcd_pkg::CW_K3 | mcd_pkg::CW_K4))
        bus = cur.reg_b;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K2 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K4))
        bus = cur.reg_c;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_XO, mcd_pkg::CW_NONE))
        bus = cur.reg_x;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4)) begin
        bus = mem_rdata;
        if (cur.mar == mcd_pkg::PORT_ADDR) begin
          bus     = key_byte;
          res.key = 1'b1;
        end
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_NOFLG, mcd_pkg::CW_NONE))
        st.flg_sup = 1'b1;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K3 | mcd_pkg::CW_HI,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4))
        bus = cur.pc[15:8];
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_HI | mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4))
        bus = cur.pc[7:0];
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K2 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K3 | mcd_pkg::CW_HI))
        bus = {6'b000000, cur.zero, cur.carry};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K3))
        bus = mcd_pkg::CONST_BYTE;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K3))
        bus = irq_vector;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K3))
        res.ack = 1'b1;
      // IDT outputs are crossed: the low-looking decode gives the high byte
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K3 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_HI))
        bus = cur.vtb[15:8];
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K3 | mcd_pkg::CW_K4 | mcd_pkg::CW_HI,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K2))
        bus = cur.vtb[7:0];

      // ALU: the decodes are disjoint, so at most one fires per word
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a} + {2'b00, cur.reg_b};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K2,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a} + {2'b00, ~cur.reg_b} + 10'd1;
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K4,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a} + {2'b00, ~cur.reg_b} + {9'd0, cur.carry};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a & cur.reg_b};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1,
                       mcd_pkg::CW_K2 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a | cur.reg_b};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K2,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K3 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a ^ cur.reg_b};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K2 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {2'b00, cur.reg_a} + {2'b00, cur.reg_b} + {9'd0, cur.carry};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K1 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {1'b0, cur.reg_a, 1'b0};
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K4)) begin
        alu_hit = 1'b1;
        alu     = {3'b000, cur.reg_a[7:1]};
      end
      if (alu_hit) begin
        bus = alu[7:0];
        if (!st.flg_sup) begin
          st.zero  = (alu[7:0] == 8'h00);
          st.carry = alu[8];
        end
        st.flg_sup = 1'b0;
      end

      // phase two: latch in fixed order
      if (mcd_pkg::sig(cw, mcd_pkg::CW_SPACT, mcd_pkg::CW_NONE)) begin
        s     = mcd_pkg::sig(cw, mcd_pkg::CW_SPNOT, mcd_pkg::CW_NONE) ? st.sp + 16'd1
                                                                      : st.sp - 16'd1;
        st.sp = s | mcd_pkg::STACK_PAGE;
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_SPI, mcd_pkg::CW_NONE))
        st.sp = {8'h00, bus} | mcd_pkg::STACK_PAGE;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_FPI, mcd_pkg::CW_NONE))
        st.fp = {8'h00, bus} | mcd_pkg::STACK_PAGE;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_AI, mcd_pkg::CW_NONE)) st.reg_a = bus;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_XI, mcd_pkg::CW_NONE)) st.reg_x = bus;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_BI, mcd_pkg::CW_NONE)) st.reg_b = bus;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_CI, mcd_pkg::CW_NONE)) st.reg_c = bus;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_RI, mcd_pkg::CW_NONE)) begin
        wr.we   = 1'b1;
        wr.addr = st.mar[mcd_pkg::MEM_ADDR_BITS-1:0];
        wr.data = bus;
        res.chr = (st.mar == mcd_pkg::PORT_ADDR);
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_II, mcd_pkg::CW_NONE)) st.ir = bus;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_MI | mcd_pkg::CW_HI, mcd_pkg::CW_NONE))
        st.mar = {bus, st.mar[7:0]};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_MI, mcd_pkg::CW_HI))
        st.mar = {st.mar[15:8], bus};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_PI | mcd_pkg::CW_HI, mcd_pkg::CW_NONE))
        st.pc = {bus, st.pc[7:0]};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_PI, mcd_pkg::CW_HI))
        st.pc = {st.pc[15:8], bus};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K2 | mcd_pkg::CW_K4 | mcd_pkg::CW_HI,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K3)) begin
        st.carry = bus[0];
        st.zero  = bus[1];
      end
      if (mcd_pkg::sig(cw, mcd_pkg::CW_ME, mcd_pkg::CW_NONE)) st.mar = st.mar + 16'd1;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_PE, mcd_pkg::CW_NONE)) st.pc = st.pc + 16'd1;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K4 | mcd_pkg::CW_HI,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3))
        st.int_en = 1'b1;
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K1 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K0 | mcd_pkg::CW_K2 | mcd_pkg::CW_K3 | mcd_pkg::CW_HI))
        st.int_en = 1'b0;
      // IDT loads are crossed as well
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K4,
                       mcd_pkg::CW_K2 | mcd_pkg::CW_K3 | mcd_pkg::CW_HI))
        st.vtb = {bus, st.vtb[7:0]};
      if (mcd_pkg::sig(cw, mcd_pkg::CW_K0 | mcd_pkg::CW_K1 | mcd_pkg::CW_K4 | mcd_pkg::CW_HI,
                       mcd_pkg::CW_K2 | mcd_pkg::CW_K3))
        st.vtb = {st.vtb[15:8], bus};
      res.eoi = mcd_pkg::sig(cw, mcd_pkg::CW_RS, mcd_pkg::CW_NONE);
    end

    res.bus = bus;
    nxt     = st;
  end

endmodule

`default_nettype wire

// ----- rtl/core/microcoded_cpu_datapath_step.sv -----
// Microcoded 8-bit CPU datapath: one control word or memory load per item.
// Items pass the execute stage and then the output register. Throughput:
// one item per cycle while the output is not stalled; the main memory read
// of the next item is issued at accept, with the memory address forwarded
// from the step ahead. Reset: registers reset, then a clearing pass zeroes
// all 2^MEM_ADDR_BITS (65536) main memory entries while in_ready is low.
`default_nettype none

module microcoded_cpu_datapath_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [23:0] control_word,
  input  wire logic [15:0] load_address,
  input  wire logic [7:0]  load_data,
  input  wire logic [7:0]  irq_vector,
  input  wire logic [7:0]  key_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       bus_value,
  output logic [7:0]       opcode,
  output logic             carry_flag,
  output logic             zero_flag,
  output logic             int_enable_out,
  output logic             end_of_instruction,
  output logic             char_out_valid,
  output logic             key_consumed,
  output logic             irq_ack
);

  // Architectural register state and the clearing sequencer
  mcd_pkg::arch_t                    arch;
  mcd_pkg::arch_t                    arch_next;
  logic                              clearing;
  logic [mcd_pkg::MEM_ADDR_BITS-1:0] clr_addr;

  // Execute stage: the item whose memory read data is on the RAM output
  logic        ex_valid;
  logic        ex_op;
  logic [23:0] ex_cw;
  logic [15:0] ex_laddr;
  logic [7:0]  ex_ldata;
  logic [7:0]  ex_irq;
  logic [7:0]  ex_key;
  logic        fwd_hit;
  logic [7:0]  fwd_data;

  mcd_pkg::step_res_t ex_res;
  mcd_pkg::mem_wr_t   ex_wr;

  logic                              ex_fire;
  logic                              accept;
  logic                              ram_we;
  logic [mcd_pkg::MEM_ADDR_BITS-1:0] ram_waddr;
  logic [7:0]                        ram_wdata;
  logic [mcd_pkg::MEM_ADDR_BITS-1:0] ram_raddr;
  logic [7:0]                        ram_rdata;
  logic [7:0]                        mem_rdata;

  // Advance the execute stage whenever the output register is free or drains
  assign ex_fire  = ex_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!ex_valid || ex_fire);
  assign accept   = in_valid && in_ready;

  // Clearing pass owns the write port; otherwise the retiring step writes
  assign ram_we    = clearing || (ex_fire && ex_wr.we);
  assign ram_waddr = clearing ? clr_addr : ex_wr.addr;
  assign ram_wdata = clearing ? 8'h00 : ex_wr.data;

  // Read at the memory address that the step ahead leaves behind
  assign ram_raddr = ex_fire ? arch_next.mar[mcd_pkg::MEM_ADDR_BITS-1:0]
                             : arch.mar[mcd_pkg::MEM_ADDR_BITS-1:0];

  // RAM returns old data on a same-address collision: use the forwarded byte
  assign mem_rdata = fwd_hit ? fwd_data : ram_rdata;

  mcd_ram #(
    .WIDTH(8),
    .DEPTH(mcd_pkg::MEM_DEPTH)
  ) u_main_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mcd_exec u_exec (
    .op          (ex_op),
    .cw          (ex_cw),
    .load_address(ex_laddr),
    .load_data   (ex_ldata),
    .irq_vector  (ex_irq),
    .key_byte    (ex_key),
    .mem_rdata   (mem_rdata),
    .cur         (arch),
    .nxt         (arch_next),
    .res         (ex_res),
    .wr          (ex_wr)
  );

  // Clearing sequencer: sweep every memory entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + {{(mcd_pkg::MEM_ADDR_BITS-1){1'b0}}, 1'b1};
      if (clr_addr == {mcd_pkg::MEM_ADDR_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Architectural state: commit when the execute stage retires
  always_ff @(posedge clk) begin
    if (rst) begin
      arch.reg_a   <= 8'h00;
      arch.reg_b   <= 8'h00;
      arch.reg_c   <= 8'h00;
      arch.reg_x   <= 8'h00;
      arch.pc      <= 16'h0000;
      arch.mar     <= 16'h0000;
      arch.sp      <= mcd_pkg::STACK_PAGE;
      arch.fp      <= mcd_pkg::STACK_PAGE;
      arch.ir      <= 8'h00;
      arch.vtb     <= 16'h0000;
      arch.carry   <= 1'b0;
      arch.zero    <= 1'b0;
      arch.int_en  <= 1'b0;
      arch.flg_sup <= 1'b0;
    end else if (ex_fire) begin
      arch <= arch_next;
    end
  end

  // Execute stage capture; payload holds while the stage is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_op    <= op;
      ex_cw    <= control_word;
      ex_laddr <= load_address;
      ex_ldata <= load_data;
      ex_irq   <= irq_vector;
      ex_key   <= key_byte;
      fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
      fwd_data <= ram_wdata;
    end
  end

  // Output register: parts the result side from the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      bus_value          <= ex_res.bus;
      opcode             <= arch_next.ir;
      carry_flag         <= arch_next.carry;
      zero_flag          <= arch_next.zero;
      int_enable_out     <= arch_next.int_en;
      end_of_instruction <= ex_res.eoi;
      char_out_valid     <= ex_res.chr;
      key_consumed       <= ex_res.key;
      irq_ack            <= ex_res.ack;
    end
  end

endmodule

`default_nettype wire
